/* rtl/cva_pkg.sv */
// ----------------------------------------------------------------------------
// cva_pkg
// Shared types and constants of the class vote accumulator: table geometry,
// operation and register codes, sequencer states and the structs that pass
// between the sequencer, the counter table and the top level.
// ----------------------------------------------------------------------------
package cva_pkg;

  localparam int NUM_CLASSES = 32;
  localparam int COUNT_BITS  = 8;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int VOTE_W      = 8;
  localparam int THR_W       = 8;
  localparam int CHOSEN_W    = 5;
  localparam int CMP_W       = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_POLL = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_DEFAULT   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_e;

  // Access request from the sequencer to the counter table.
  typedef struct packed {
    logic                  rd_en;
    logic [CLS_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [CLS_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  clear;
  } tbl_req_t;

  // One result item.
  typedef struct packed {
    logic                bad_class;
    logic                decided;
    logic [CHOSEN_W-1:0] chosen_class;
  } res_t;

endpackage

/* rtl/cva_count_table.sv */
// ----------------------------------------------------------------------------
// cva_count_table
// Per-class counter storage: one write and one registered read per cycle,
// with a valid bit per entry so that reset and a decision clear the whole
// table at once.
// ----------------------------------------------------------------------------
module cva_count_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cva_pkg::tbl_req_t              req_i,
  output logic [cva_pkg::COUNT_BITS-1:0] rd_data_o
);
  import cva_pkg::*;

  logic [COUNT_BITS-1:0]  mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] valid_q;
  logic [COUNT_BITS-1:0]  rd_data_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // An entry never written since the last clear reads as zero.
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/cva_core.sv */
// ----------------------------------------------------------------------------
// cva_core
// Sequencer with a compare unit for the scan. An in-range add reads, increments
// with saturation and writes back one counter; a poll walks the table one entry
// per cycle keeping the running maximum, then decides against the threshold.
// ----------------------------------------------------------------------------
module cva_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cva_pkg::op_e                   in_op_i,
  input  logic [cva_pkg::VOTE_W-1:0]     in_class_i,
  input  logic [cva_pkg::THR_W-1:0]      thr_i,
  input  logic [cva_pkg::CHOSEN_W-1:0]   dflt_i,
  output cva_pkg::tbl_req_t              tbl_req_o,
  input  logic [cva_pkg::COUNT_BITS-1:0] tbl_rd_data_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output cva_pkg::res_t                  res_o
);
  import cva_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_e                state_q, state_d;
  logic [CLS_W:0]        cnt_q, cnt_d;
  logic [CLS_W-1:0]      idx_q, idx_d;
  logic [COUNT_BITS-1:0] best_q, best_d;
  logic [CLS_W-1:0]      best_idx_q, best_idx_d;
  res_t                  res_q, res_d;
  logic                  class_bad;
  logic                  cmp_gt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

  assign class_bad = ({1'b0, in_class_i} >= (VOTE_W+1)'(NUM_CLASSES));

  // The compare unit for the running maximum during a scan.
  assign cmp_gt = (tbl_rd_data_i > best_q);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    res_d      = res_q;
    tbl_req_o  = '0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_ADD) begin
            if (class_bad) begin
              res_d   = '{bad_class: 1'b1, decided: 1'b0, chosen_class: '0};
              state_d = ST_DONE;
            end else begin
              tbl_req_o.rd_en   = 1'b1;
              tbl_req_o.rd_addr = in_class_i[CLS_W-1:0];
              idx_d             = in_class_i[CLS_W-1:0];
              state_d           = ST_ADD;
            end
          end else begin
            tbl_req_o.rd_en   = 1'b1;
            tbl_req_o.rd_addr = '0;
            cnt_d             = (CLS_W+1)'(1);
            idx_d             = '0;
            best_d            = '0;
            best_idx_d        = '0;
            state_d           = ST_SCAN;
          end
        end
      end
      ST_ADD: begin
        tbl_req_o.wr_en   = 1'b1;
        tbl_req_o.wr_addr = idx_q;
        tbl_req_o.wr_data = (tbl_rd_data_i == COUNT_MAX) ? tbl_rd_data_i
                                                         : tbl_rd_data_i + 1'b1;
        res_d   = '{bad_class: 1'b0, decided: 1'b0, chosen_class: '0};
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (cmp_gt) begin
          best_d     = tbl_rd_data_i;
          best_idx_d = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (cnt_q == (CLS_W+1)'(NUM_CLASSES)) begin
          state_d = ST_DECIDE;
        end else begin
          tbl_req_o.rd_en   = 1'b1;
          tbl_req_o.rd_addr = cnt_q[CLS_W-1:0];
          cnt_d             = cnt_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (CMP_W'(best_q) >= CMP_W'(thr_i)) begin
          res_d = '{bad_class: 1'b0, decided: 1'b1,
                    chosen_class: CHOSEN_W'(best_idx_q)};
          tbl_req_o.clear = 1'b1;
        end else begin
          res_d = '{bad_class: 1'b0, decided: 1'b0, chosen_class: dflt_i};
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

`ifndef NO_ASSERTIONS
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !in_ready_o)
    else $error("input accepted while a result is pending");

  a_clear_only_on_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req_o.clear |=> (res_valid_o && res_o.decided && !res_o.bad_class))
    else $error("table cleared without a decided result");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= (CLS_W+1)'(NUM_CLASSES)))
    else $error("scan ran past the table");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.decided && res_o.bad_class))
    else $error("result both decided and bad class");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tbl_req_o.wr_en && (tbl_req_o.rd_en || tbl_req_o.clear)))
    else $error("table write collides with read or clear");
`endif

endmodule

/* rtl/class_vote_accumulator.sv */
// ----------------------------------------------------------------------------
// class_vote_accumulator
// Histogram vote with argmax decision over a table of per-class counters.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Contents
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tuser[0] opcode, tdata[7:0] vote_class
//  m_axis    | out       | tdata[4:0] chosen_class, tuser[0] decided,
//            |           | tuser[1] bad_class
//  cfg       | in        | write-only: index 0 vote_threshold, 1 default_class
//
// An add passes through a registered table read, a saturating write-back
// and a hand-off to the output register. An out-of-range add skips the
// table. During a poll the scan comparator visits one counter per cycle
// through the table's read port. Reset clears every counter at once through
// per-entry valid bits, so no clearing pass is needed; a decided poll
// clears the table the same way. The result sits in an output register,
// so a stalled master side does not stop the next transfer from being
// taken; only a second result waits.
//
module class_vote_accumulator (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] vote_class
  input  logic [0:0] s_axis_tuser_i,   // [0] opcode
  // Result stream.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [4:0] chosen_class, rest zero
  output logic [1:0] m_axis_tuser_o,   // [0] decided, [1] bad_class
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [cva_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cva_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import cva_pkg::*;

  logic [THR_W-1:0]      thr_q;
  logic [CHOSEN_W-1:0]   dflt_q;
  tbl_req_t              tbl_req;
  logic [COUNT_BITS-1:0] tbl_rd_data;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  out_valid_q;
  res_t                  out_res_q;

  // Configuration registers; to be written only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_W'(5);
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
        REG_DEFAULT:   dflt_q <= cfg_data_i[CHOSEN_W-1:0];
        default: ;
      endcase
    end
  end

  cva_count_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (tbl_rd_data)
  );

  cva_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_op_i       (op_e'(s_axis_tuser_i[0])),
    .in_class_i    (s_axis_tdata_i[VOTE_W-1:0]),
    .thr_i         (thr_q),
    .dflt_i        (dflt_q),
    .tbl_req_o     (tbl_req),
    .tbl_rd_data_i (tbl_rd_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = 8'(out_res_q.chosen_class);
  assign m_axis_tuser_o  = {out_res_q.bad_class, out_res_q.decided};

endmodule

/* tb/sv/class_vote_accumulator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Class vote accumulator checker
// Watches the input, result and configuration ports of the vote accumulator.
// It keeps its own copy of the counter table and settings, and it predicts
// each result when the input transfer happens. Results are compared in order.
// ----------------------------------------------------------------------------
module class_vote_accumulator_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [7:0]                     in_data_i,     // [7:0] vote_class
  input  logic [0:0]                     in_user_i,     // [0] opcode
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [7:0]                     out_data_i,    // [4:0] chosen_class, rest zero
  input  logic [1:0]                     out_user_i,    // [0] decided, [1] bad_class
  input  logic                           cfg_we_i,
  input  logic [cva_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cva_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             failures_o,
  output int                             outstanding_o,
  output int                             decisions_o,
  output int                             rejected_o,
  output int                             saturated_o
);
  import cva_pkg::*;

  localparam logic [THR_W-1:0] THRESHOLD_AT_RESET = 8'd5;

  logic [COUNT_BITS-1:0] class_tally [NUM_CLASSES];
  logic [THR_W-1:0]      threshold_q;
  logic [CHOSEN_W-1:0]   fallback_q;
  res_t                  awaited_results [$];

  task automatic fail_note(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    failures_o++;
  endtask

  // Applies one vote or poll to the local table and returns its result.
  function automatic res_t tally_item(op_e op, logic [VOTE_W-1:0] cls);
    res_t                  res;
    int                    lead;
    logic [COUNT_BITS-1:0] lead_count;
    res = '0;
    if (op == OP_ADD) begin
      if (cls >= NUM_CLASSES) begin
        res.bad_class = 1'b1;
        rejected_o++;
      end else if (class_tally[cls[CLS_W-1:0]] == '1) begin
        saturated_o++;
      end else begin
        class_tally[cls[CLS_W-1:0]] = class_tally[cls[CLS_W-1:0]] + 1'b1;
      end
    end else begin
      // Strictly greater keeps the lowest index on a tie.
      lead = 0;
      lead_count = class_tally[0];
      for (int i = 1; i < NUM_CLASSES; i++) begin
        if (class_tally[i] > lead_count) begin
          lead_count = class_tally[i];
          lead = i;
        end
      end
      if (lead_count >= threshold_q) begin
        res.chosen_class = lead[CHOSEN_W-1:0];
        res.decided = 1'b1;
        decisions_o++;
        foreach (class_tally[i]) class_tally[i] = '0;
      end else begin
        res.chosen_class = fallback_q;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      foreach (class_tally[i]) class_tally[i] = '0;
      threshold_q = THRESHOLD_AT_RESET;
      fallback_q = '0;
      awaited_results.delete();
      outstanding_o = 0;
    end else begin
      // The result side goes first: a result always belongs to an older item.
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          fail_note($sformatf("result with nothing pending: class %0d decided %0b bad %0b",
                              out_data_i[CHOSEN_W-1:0], out_user_i[0], out_user_i[1]));
        end else begin
          want = awaited_results.pop_front();
          if (out_data_i[CHOSEN_W-1:0] !== want.chosen_class)
            fail_note($sformatf("chosen_class %0d, predicted %0d",
                                out_data_i[CHOSEN_W-1:0], want.chosen_class));
          if (out_user_i[0] !== want.decided)
            fail_note($sformatf("decided %0b, predicted %0b", out_user_i[0], want.decided));
          if (out_user_i[1] !== want.bad_class)
            fail_note($sformatf("bad_class %0b, predicted %0b",
                                out_user_i[1], want.bad_class));
          if (out_data_i[7:CHOSEN_W] !== '0)
            fail_note($sformatf("tdata padding %0h is not zero", out_data_i[7:CHOSEN_W]));
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(tally_item(op_e'(in_user_i[0]), in_data_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_THRESHOLD) threshold_q = cfg_data_i[THR_W-1:0];
        else if (cfg_idx_i == REG_DEFAULT) fallback_q = cfg_data_i[CHOSEN_W-1:0];
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

/* tb/sv/class_vote_accumulator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Class vote accumulator testbench
// Drives votes and polls into the accumulator under several threshold and
// default settings and several idling patterns, while a separate checker
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module class_vote_accumulator_test;
  import cva_pkg::*;

  // Random phase plan. Each phase sets both registers, an idling pattern and
  // a vote mix. The focus class gets most votes so that thresholds are hit;
  // it is redrawn every PH_REFOCUS items.
  localparam int NUM_PHASES = 8;
  localparam int PH_THR     [NUM_PHASES] = '{3, 1, 255, 10, 0, 128, 2, 5};
  localparam int PH_DEF     [NUM_PHASES] = '{7, 31, 16, 21, 3, 10, 0, 0};
  localparam int PH_GAP     [NUM_PHASES] = '{0, 75, 0, 9, 0, 0, 75, 9};
  localparam int PH_STALL   [NUM_PHASES] = '{0, 0, 75, 9, 0, 75, 0, 9};
  localparam int PH_ITEMS   [NUM_PHASES] = '{300, 250, 350, 350, 100, 300, 200, 100};
  localparam int PH_POLL    [NUM_PHASES] = '{12, 12, 1, 10, 15, 3, 12, 12};
  localparam int PH_FOCUS   [NUM_PHASES] = '{50, 30, 92, 60, 30, 85, 40, 40};
  localparam int PH_REFOCUS [NUM_PHASES] = '{40, 40, 1000, 40, 40, 200, 40, 40};
  localparam int BAD_PCT       = 6;
  // The holdoff phase starts with the receiver closed for a long stretch,
  // so the result register fills and the block refuses new transfers.
  localparam int HOLDOFF_PHASE = 5;
  localparam int HOLDOFF_LEN   = 400;
  // In this phase the sender also stops halfway until every result is back.
  localparam int PAUSE_PHASE   = 3;
  // A poll scans every counter, so this bounds the longest busy stretch.
  localparam int DRAIN_CYCLES  = NUM_CLASSES + 8;

  logic                  clk;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data  = '0;
  logic [0:0]            in_user  = OP_ADD;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_data;
  logic [1:0]            out_user;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int failures;
  int outstanding;
  int decisions;
  int rejected;
  int saturated;

  int gap_pct      = 0;
  int stall_pct    = 0;
  int holdoff_left = 0;
  int items_sent   = 0;
  int reg_writes   = 0;

  class_vote_accumulator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_user),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  class_vote_accumulator_checker vote_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .in_user_i     (in_user),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .out_user_i    (out_user),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .failures_o    (failures),
    .outstanding_o (outstanding),
    .decisions_o   (decisions),
    .rejected_o    (rejected),
    .saturated_o   (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side. A requested holdoff is counted down here cycle by cycle;
  // otherwise the ready line stalls at the current rate.
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        out_ready <= 1'b0;
        holdoff_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one item, with random idle cycles in front of it, and returns at
  // the rising edge where the transfer happens. The valid line stays high so
  // that a following item can go out back to back.
  task automatic send_item(op_e op, logic [VOTE_W-1:0] cls);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_user  <= op;
    in_data  <= cls;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    items_sent++;
  endtask

  // Drops the valid line and waits until every predicted result has come.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Registers are only written once the block has gone idle.
  task automatic write_reg(reg_idx_e idx, int unsigned val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic run_phase(int idx);
    int                r;
    op_e               op;
    logic [VOTE_W-1:0] cls;
    logic [VOTE_W-1:0] focus;
    wait_drained();
    write_reg(REG_THRESHOLD, PH_THR[idx]);
    write_reg(REG_DEFAULT, PH_DEF[idx]);
    gap_pct   = PH_GAP[idx];
    stall_pct = PH_STALL[idx];
    if (idx == HOLDOFF_PHASE) holdoff_left = HOLDOFF_LEN;
    focus = '0;
    for (int n = 0; n < PH_ITEMS[idx]; n++) begin
      if (n % PH_REFOCUS[idx] == 0) focus = VOTE_W'($urandom_range(NUM_CLASSES - 1));
      if (idx == PAUSE_PHASE && n == PH_ITEMS[idx] / 2) wait_drained();
      r = $urandom_range(99);
      if (r < PH_POLL[idx]) begin
        // The class field of a poll is ignored but still carries noise.
        op  = OP_POLL;
        cls = VOTE_W'($urandom_range(255));
      end else if (r < PH_POLL[idx] + BAD_PCT) begin
        op  = OP_ADD;
        cls = VOTE_W'($urandom_range(255, NUM_CLASSES));
      end else begin
        op  = OP_ADD;
        cls = ($urandom_range(99) < PH_FOCUS[idx]) ? focus
                                                    : VOTE_W'($urandom_range(NUM_CLASSES - 1));
      end
      send_item(op, cls);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: a poll of the empty table
    // falls back to the default class, and out-of-range votes are flagged
    // without touching any counter.
    send_item(OP_POLL, 8'd0);
    send_item(OP_ADD, 8'd0);
    send_item(OP_ADD, 8'd31);
    send_item(OP_ADD, 8'd32);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'h80);
    send_item(OP_POLL, 8'd255);
    // Class 0 climbs to the threshold of five and is decided.
    repeat (4) send_item(OP_ADD, 8'd0);
    send_item(OP_POLL, 8'd0);

    // A threshold of one and the highest default class. A tie between two
    // classes goes to the lower index.
    wait_drained();
    write_reg(REG_THRESHOLD, 1);
    write_reg(REG_DEFAULT, 31);
    send_item(OP_POLL, 8'd0);
    send_item(OP_ADD, 8'd31);
    send_item(OP_ADD, 8'd31);
    send_item(OP_ADD, 8'd5);
    send_item(OP_ADD, 8'd5);
    send_item(OP_POLL, 8'd0);
    send_item(OP_POLL, 8'd0);

    // A zero threshold decides on every poll, class 0 for an empty table.
    wait_drained();
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_DEFAULT, 10);
    send_item(OP_POLL, 8'd0);
    send_item(OP_ADD, 8'd3);
    send_item(OP_POLL, 8'd0);

    // Random phases. The one with the highest threshold keeps a single focus
    // class long enough to drive its counter into saturation.
    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d vote and poll transfers, %0d register writes, %0d random phases.",
             items_sent, reg_writes, NUM_PHASES);
    $display("Seen: %0d decided polls, %0d out-of-range votes, %0d votes on a full counter.",
             decisions, rejected, saturated);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
